@@ rtl/core/pse_pkg.sv @@
package pse_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned WidthW = 12;
  localparam int unsigned ColorW = 32;
  localparam int unsigned VertW  = 18;
  localparam int unsigned DeltaW = 17;
  localparam int unsigned SqW    = 35;
  localparam int unsigned RadW   = 64;
  localparam int unsigned LenW   = 32;
  localparam int unsigned NumW   = 45;
  localparam int unsigned UnitW  = 16;

  localparam logic [1:0] CfgCamX = 2'd0;
  localparam logic [1:0] CfgCamY = 2'd1;

  localparam logic signed [UnitW-1:0] UnitOne = 16'sd16384;
  localparam logic signed [VertW+2:0] VMax = 21'sd131071;
  localparam logic signed [VertW+2:0] VMin = -21'sd131072;

  typedef struct packed {
    logic signed [CoordW-1:0] x0;
    logic signed [CoordW-1:0] y0;
    logic [WidthW-1:0]        w0;
    logic [ColorW-1:0]        c0;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic [WidthW-1:0]        w1;
    logic [ColorW-1:0]        c1;
  } seg_t;

endpackage

@@ rtl/core/pse_front.sv @@
module pse_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           take,
  input  logic signed [pse_pkg::CoordW-1:0] x,
  input  logic signed [pse_pkg::CoordW-1:0] y,
  input  logic [pse_pkg::WidthW-1:0]     w,
  input  logic [pse_pkg::ColorW-1:0]     c,
  input  logic                           start,
  output logic                           seg_vld,
  output pse_pkg::seg_t                  seg
);
  import pse_pkg::*;

  logic signed [CoordW-1:0] px_r, py_r;
  logic [WidthW-1:0]        pw_r;
  logic [ColorW-1:0]        pc_r;
  logic                     have_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      px_r <= '0; py_r <= '0; pw_r <= '0; pc_r <= '0;
    end else if (take) begin
      have_r <= 1'b1;
      px_r <= x; py_r <= y; pw_r <= w; pc_r <= c;
    end
  end

  assign seg_vld = take && have_r && !start && ((x != px_r) || (y != py_r));
  assign seg = '{x0: px_r, y0: py_r, w0: pw_r, c0: pc_r, x1: x, y1: y, w1: w, c1: c};

endmodule

@@ rtl/core/pse_queue.sv @@
module pse_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  pse_pkg::seg_t wdata,
  output logic          full,
  input  logic          rd,
  output logic          empty,
  output pse_pkg::seg_t rdata
);
  import pse_pkg::*;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  seg_t mem_r [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full  = (cnt_r == (AW+1)'(Depth));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

endmodule

@@ rtl/core/pse_back.sv @@
module pse_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               seg_vld,
  input  pse_pkg::seg_t                      seg,
  output logic                               seg_take,
  input  logic signed [pse_pkg::CoordW-1:0]  cam_x,
  input  logic signed [pse_pkg::CoordW-1:0]  cam_y,
  output logic                               out_vld,
  input  logic                               out_take,
  output logic signed [pse_pkg::VertW-1:0]   vx,
  output logic signed [pse_pkg::VertW-1:0]   vy,
  output logic [pse_pkg::ColorW-1:0]         vc,
  output logic                               vend,
  output logic                               vside,
  output logic                               vlast
);
  import pse_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQ   = 7'b0000010,
    S_SQRT = 7'b0000100,
    S_DIVX = 7'b0001000,
    S_DIVY = 7'b0010000,
    S_OFS  = 7'b0100000,
    S_EMIT = 7'b1000000
  } st_t;

  st_t st_r;
  seg_t s_r;
  logic signed [DeltaW-1:0] dx_r, dy_r;
  logic [RadW-1:0] rad_r;
  logic [LenW-1:0] root_r;
  logic [LenW-1:0] rem_r;
  logic [5:0]      cnt_r;
  logic [NumW-1:0] num_r;
  logic [NumW-1:0] drem_r;
  logic [UnitW:0]  q_r;
  logic signed [UnitW-1:0] ux_r, uy_r;
  logic signed [UnitW-1:0] ax_r, ay_r, bx_r, by_r;
  logic [1:0] ofs_r;
  logic [1:0] vi_r;

  // sqrt step
  logic [LenW+1:0] trial;
  logic [LenW+1:0] rem2;
  assign rem2  = {rem_r, rad_r[RadW-1 -: 2]};
  assign trial = {root_r, 2'b01};

  // divide step
  logic [NumW:0] dsh;
  assign dsh = {drem_r, num_r[NumW-1]};

  logic [DeltaW-1:0] mag;
  assign mag = (st_r == S_DIVX) ? (dx_r[DeltaW-1] ? -dx_r : dx_r)
                                : (dy_r[DeltaW-1] ? -dy_r : dy_r);

  // offset: one product per cycle
  logic signed [UnitW-1:0] nsel;
  logic [WidthW-1:0] wsel;
  logic [UnitW-1:0] nmag;
  logic [WidthW+UnitW:0] prod;
  logic [UnitW-1:0] omag;
  always_comb begin
    unique case (ofs_r)
      2'd0: begin nsel = -uy_r; wsel = s_r.w0; end
      2'd1: begin nsel = ux_r;  wsel = s_r.w0; end
      2'd2: begin nsel = -uy_r; wsel = s_r.w1; end
      default: begin nsel = ux_r; wsel = s_r.w1; end
    endcase
    nmag = nsel[UnitW-1] ? -nsel : nsel;
    prod = (WidthW+UnitW+1)'(wsel) * (WidthW+UnitW+1)'(nmag) + (WidthW+UnitW+1)'(16384);
    omag = UnitW'(prod >> 15);
  end

  // vertex
  logic signed [VertW+2:0] bx, by, tx, ty;
  logic signed [UnitW-1:0] ox, oy;
  always_comb begin
    if (vi_r[1]) begin
      bx = 21'(s_r.x1) - 21'(cam_x); by = 21'(s_r.y1) - 21'(cam_y);
      ox = bx_r; oy = by_r;
    end else begin
      bx = 21'(s_r.x0) - 21'(cam_x); by = 21'(s_r.y0) - 21'(cam_y);
      ox = ax_r; oy = ay_r;
    end
    tx = vi_r[0] ? bx - 21'(ox) : bx + 21'(ox);
    ty = vi_r[0] ? by - 21'(oy) : by + 21'(oy);
    vx = (tx > VMax) ? VMax[VertW-1:0] : (tx < VMin) ? VMin[VertW-1:0] : tx[VertW-1:0];
    vy = (ty > VMax) ? VMax[VertW-1:0] : (ty < VMin) ? VMin[VertW-1:0] : ty[VertW-1:0];
    vc = vi_r[1] ? s_r.c1 : s_r.c0;
  end
  assign vend  = vi_r[1];
  assign vside = vi_r[0];
  assign vlast = (vi_r == 2'd3);
  assign out_vld  = (st_r == S_EMIT);
  assign seg_take = (st_r == S_IDLE) && seg_vld;

  logic [UnitW:0] qc;
  assign qc = (q_r > UnitW'(UnitOne)) ? (UnitW+1)'(UnitOne) : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      vi_r <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: if (seg_vld) begin
          s_r  <= seg;
          dx_r <= 17'(seg.x1) - 17'(seg.x0);
          dy_r <= 17'(seg.y1) - 17'(seg.y0);
          st_r <= S_SQ;
        end
        S_SQ: begin
          rad_r  <= {1'b0, SqW'(34'(dx_r * dx_r)) + SqW'(34'(dy_r * dy_r)), 28'd0};
          root_r <= '0; rem_r <= '0; cnt_r <= '0;
          st_r <= S_SQRT;
        end
        S_SQRT: begin
          rad_r <= rad_r << 2;
          if (rem2 >= trial) begin
            rem_r  <= LenW'(rem2 - trial);
            root_r <= {root_r[LenW-2:0], 1'b1};
          end else begin
            rem_r  <= rem2[LenW-1:0];
            root_r <= {root_r[LenW-2:0], 1'b0};
          end
          if (cnt_r == 6'd31) begin
            cnt_r <= '0; st_r <= S_DIVX; drem_r <= '0; q_r <= '0;
            num_r <= '0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DIVX, S_DIVY: begin
          if (cnt_r == 6'd0) begin
            num_r  <= {mag, 28'd0} + NumW'(root_r >> 1);
            drem_r <= '0; q_r <= '0;
            cnt_r  <= 6'd1;
          end else begin
            num_r <= num_r << 1;
            if (dsh >= (NumW+1)'(root_r)) begin
              drem_r <= NumW'(dsh - (NumW+1)'(root_r));
              q_r <= {q_r[UnitW-1:0], 1'b1};
            end else begin
              drem_r <= dsh[NumW-1:0];
              q_r <= {q_r[UnitW-1:0], 1'b0};
            end
            if (cnt_r == 6'd46) begin
              cnt_r <= '0;
              if (st_r == S_DIVX) begin
                ux_r <= dx_r[DeltaW-1] ? -UnitW'(qc) : UnitW'(qc);
                st_r <= S_DIVY;
              end else begin
                uy_r <= dy_r[DeltaW-1] ? -UnitW'(qc) : UnitW'(qc);
                ofs_r <= '0;
                st_r <= S_OFS;
              end
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        S_OFS: begin
          unique case (ofs_r)
            2'd0: ax_r <= nsel[UnitW-1] ? -omag : omag;
            2'd1: ay_r <= nsel[UnitW-1] ? -omag : omag;
            2'd2: bx_r <= nsel[UnitW-1] ? -omag : omag;
            default: by_r <= nsel[UnitW-1] ? -omag : omag;
          endcase
          ofs_r <= ofs_r + 1'b1;
          if (ofs_r == 2'd3) begin
            vi_r <= '0; st_r <= S_EMIT;
          end
        end
        S_EMIT: if (out_take) begin
          vi_r <= vi_r + 1'b1;
          if (vi_r == 2'd3) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/polyline_strip_extruder.sv @@
// channel | handshake        | payload
// in      | in_push/in_full  | point_x, point_y, point_width, point_color, start_strip
// out     | out_empty/out_pop| vertex_x, vertex_y, vertex_color, which_end, normal_side, last_vertex
// cfg     | cfg_valid/ready  | cfg_index, cfg_data
// A point is classified combinationally as it is taken; a segment passes hand-off, squaring,
// a bit-serial sqrt, x and y divides and four offset products in the back end, then four vertices.
// The back end takes a new segment only after the last one's final vertex is popped.
// Synchronous active-low reset clears the previous point, queue pointers, camera and back-end state.
// A two-entry segment queue lets the front accept points while the back stalls.
module polyline_strip_extruder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic signed [15:0] in_point_x,
  input  logic signed [15:0] in_point_y,
  input  logic [11:0] in_point_width,
  input  logic [31:0] in_point_color,
  input  logic        in_start_strip,
  output logic        out_empty,
  input  logic        out_pop,
  output logic signed [17:0] out_vertex_x,
  output logic signed [17:0] out_vertex_y,
  output logic [31:0] out_vertex_color,
  output logic        out_which_end,
  output logic        out_normal_side,
  output logic        out_last_vertex,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import pse_pkg::*;

  logic signed [CoordW-1:0] cam_x_r, cam_y_r;
  logic take, seg_vld, q_full, q_empty, q_rd, out_vld;
  seg_t seg_in, seg_q;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0; cam_y_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CfgCamX) cam_x_r <= cfg_data;
      if (cfg_index == CfgCamY) cam_y_r <= cfg_data;
    end
  end

  assign in_full = q_full;
  assign take = in_push && !in_full;

  pse_front u_front (
    .clk, .rst_n, .take,
    .x(in_point_x), .y(in_point_y), .w(in_point_width), .c(in_point_color),
    .start(in_start_strip), .seg_vld, .seg(seg_in)
  );

  pse_queue #(.Depth(2)) u_queue (
    .clk, .rst_n, .wr(seg_vld), .wdata(seg_in), .full(q_full),
    .rd(q_rd), .empty(q_empty), .rdata(seg_q)
  );

  pse_back u_back (
    .clk, .rst_n, .seg_vld(!q_empty), .seg(seg_q), .seg_take(q_rd),
    .cam_x(cam_x_r), .cam_y(cam_y_r),
    .out_vld, .out_take(out_pop && out_vld),
    .vx(out_vertex_x), .vy(out_vertex_y), .vc(out_vertex_color),
    .vend(out_which_end), .vside(out_normal_side), .vlast(out_last_vertex)
  );

  assign out_empty = !out_vld;

  a_no_take_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !seg_vld) else $error("segment pushed into full queue");
  a_last_side: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_last_vertex) |-> (out_which_end && out_normal_side))
    else $error("last vertex flag misplaced");
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |-> !q_empty) else $error("queue read while empty");

endmodule

@@ bench/polyline_strip_extruder_tb.sv @@
`timescale 1ns / 100ps

module polyline_strip_extruder_tb;
  import pse_pkg::*;

  localparam logic [1:0] CfgSpare = 2'd3;
  localparam logic [1:0] CfgUnused = 2'd2;

  typedef struct {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [WidthW-1:0]        w;
    logic [ColorW-1:0]        c;
    bit                       strip_start;
    bit                       typed;
    logic signed [VertW-1:0]  tx;
    logic signed [VertW-1:0]  ty;
  } point_t;

  typedef struct {
    logic signed [VertW-1:0] x;
    logic signed [VertW-1:0] y;
    logic [ColorW-1:0]       color;
    bit                      end_sel;
    bit                      side;
    bit                      last;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic signed [15:0] in_point_x = '0;
  logic signed [15:0] in_point_y = '0;
  logic [11:0] in_point_width = '0;
  logic [31:0] in_point_color = '0;
  logic in_start_strip = 1'b0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [17:0] out_vertex_x;
  logic signed [17:0] out_vertex_y;
  logic [31:0] out_vertex_color;
  logic out_which_end;
  logic out_normal_side;
  logic out_last_vertex;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  vertex_t vertex_q[$];
  int errors = 0;
  int points_sent = 0;
  int segments_made = 0;
  int vertices_seen = 0;
  int burst_left = 0;
  bit hold_off = 1'b0;

  int cam_x = 0;
  int cam_y = 0;
  int last_x = 0;
  int last_y = 0;
  int unsigned last_w = 0;
  logic [31:0] last_c = '0;
  bit have_last = 1'b0;

  polyline_strip_extruder u_top (.*);

  always #2 clk = ~clk;

  initial begin
    #2ms;
    $display("polyline_strip_extruder test failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d (vertex %0d)", what, got, want, vertices_seen);
    errors++;
  endtask

  function automatic void queue_vertex(input vertex_t v);
    vertex_q = {vertex_q, v};
  endfunction

  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic int unit_comp(input longint d, input longint unsigned len);
    longint unsigned mag = (d < 0) ? -d : d;
    longint unsigned q = ((mag << 28) + (len >> 1)) / len;
    if (q > 16384) q = 16384;
    return (d < 0) ? -int'(q) : int'(q);
  endfunction

  function automatic int half_off(input int unsigned w, input int n);
    int unsigned mag = (n < 0) ? -n : n;
    int o = int'((w * mag + 32'd16384) >> 15);
    return (n < 0) ? -o : o;
  endfunction

  function automatic vertex_t make_vertex(input int px, input int py, input int ox, input int oy,
                                          input logic [31:0] c, input bit e, input bit s);
    vertex_t v;
    longint bx = longint'(px) - cam_x + (s ? -ox : ox);
    longint by = longint'(py) - cam_y + (s ? -oy : oy);
    if (bx > 131071) bx = 131071;
    if (bx < -131072) bx = -131072;
    if (by > 131071) by = 131071;
    if (by < -131072) by = -131072;
    v.x = bx[17:0];
    v.y = by[17:0];
    v.color = c;
    v.end_sel = e;
    v.side = s;
    v.last = e & s;
    return v;
  endfunction

  function automatic int extrude_point(input point_t p);
    longint dx, dy;
    longint unsigned sq, len;
    int ux, uy, ax, ay, bx, by;
    int made = 0;
    if (have_last && !p.strip_start) begin
      dx = longint'(p.x) - last_x;
      dy = longint'(p.y) - last_y;
      sq = dx * dx + dy * dy;
      if (sq != 0) begin
        len = root64(sq << 28);
        ux = unit_comp(dx, len);
        uy = unit_comp(dy, len);
        ax = half_off(last_w, -uy);
        ay = half_off(last_w, ux);
        bx = half_off(p.w, -uy);
        by = half_off(p.w, ux);
        queue_vertex(make_vertex(last_x, last_y, ax, ay, last_c, 0, 0));
        queue_vertex(make_vertex(last_x, last_y, ax, ay, last_c, 0, 1));
        queue_vertex(make_vertex(p.x, p.y, bx, by, p.c, 1, 0));
        queue_vertex(make_vertex(p.x, p.y, bx, by, p.c, 1, 1));
        made = 4;
      end
    end
    last_x = p.x;
    last_y = p.y;
    last_w = p.w;
    last_c = p.c;
    have_last = 1'b1;
    return made;
  endfunction

  task automatic send_point(input point_t p);
    int made;
    in_push <= 1'b1;
    in_point_x <= p.x;
    in_point_y <= p.y;
    in_point_width <= p.w;
    in_point_color <= p.c;
    in_start_strip <= p.strip_start;
    do @(posedge clk); while (!(in_push && !in_full));
    made = extrude_point(p);
    if (made != 0) begin
      segments_made++;
      if (p.typed) begin
        vertex_q[vertex_q.size() - 4].x = p.tx;
        vertex_q[vertex_q.size() - 4].y = p.ty;
      end
    end
    points_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 10);
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CfgCamX) cam_x = int'($signed(data));
    else if (idx == CfgCamY) cam_y = int'($signed(data));
  endtask

  task automatic drain;
    in_push <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic point_t random_point();
    point_t p;
    int r = $urandom_range(0, 99);
    p.typed = 1'b0;
    p.tx = '0;
    p.ty = '0;
    p.w = (r < 20) ? 12'($urandom_range(3000, 4095)) : 12'($urandom_range(0, 4095));
    p.c = $urandom;
    p.strip_start = (r < 8);
    if (r >= 8 && r < 13) begin
      p.x = 16'(last_x);
      p.y = 16'(last_y);
    end else if (r >= 13 && r < 25) begin
      p.x = 16'($urandom);
      p.y = 16'($urandom);
    end else begin
      p.x = 16'(last_x + $urandom_range(0, 1024) - 512);
      p.y = 16'(last_y + $urandom_range(0, 1024) - 512);
    end
    return p;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (vertex_q.size() == 0) begin
        report_mismatch("unexpected vertex x", out_vertex_x, 0);
      end else begin
        vertex_t e;
        e = vertex_q.pop_front();
        if (out_vertex_x !== e.x) report_mismatch("vertex_x", out_vertex_x, e.x);
        if (out_vertex_y !== e.y) report_mismatch("vertex_y", out_vertex_y, e.y);
        if (out_vertex_color !== e.color)
          report_mismatch("vertex_color", out_vertex_color, e.color);
        if (out_which_end !== e.end_sel) report_mismatch("which_end", out_which_end, e.end_sel);
        if (out_normal_side !== e.side) report_mismatch("normal_side", out_normal_side, e.side);
        if (out_last_vertex !== e.last) report_mismatch("last_vertex", out_last_vertex, e.last);
      end
      vertices_seen++;
    end
  end

  initial begin
    int mode = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_pop <= 1'b0;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_pop <= 1'b1;
        1: out_pop <= ($urandom_range(0, 3) != 0);
        default: out_pop <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial begin
    point_t dir_rows[$];
    point_t p;
    logic [15:0] cam_sets[4][2];
    dir_rows = '{
      '{16'sd0, 16'sd0, 12'd32, 32'h1122_3344, 1'b1, 1'b0, 18'sd0, 18'sd0},
      '{16'sd16, 16'sd0, 12'd64, 32'hAABB_CCDD, 1'b0, 1'b1, 18'sd0, 18'sd16},
      '{16'sd16, 16'sd0, 12'd100, 32'h0000_00FF, 1'b0, 1'b0, 18'sd0, 18'sd0},
      '{16'sd32767, 16'sd32767, 12'd4095, 32'hFFFF_FFFF, 1'b0, 1'b0, 18'sd0, 18'sd0},
      '{-16'sd32768, -16'sd32768, 12'd0, 32'h0000_0000, 1'b0, 1'b0, 18'sd0, 18'sd0},
      '{-16'sd32768, 16'sd32767, 12'd4095, 32'h8000_0001, 1'b0, 1'b0, 18'sd0, 18'sd0},
      '{16'sd32767, -16'sd32768, 12'd2048, 32'h5A5A_A5A5, 1'b0, 1'b0, 18'sd0, 18'sd0},
      '{16'sd100, 16'sd100, 12'd48, 32'h0F0F_0F0F, 1'b1, 1'b0, 18'sd0, 18'sd0},
      '{16'sd100, 16'sd100, 12'd20, 32'hF0F0_F0F0, 1'b0, 1'b0, 18'sd0, 18'sd0},
      '{16'sd100, -16'sd200, 12'd0, 32'h1234_5678, 1'b0, 1'b0, 18'sd0, 18'sd0},
      '{16'sd0, 16'sd0, 12'd4095, 32'h8765_4321, 1'b1, 1'b0, 18'sd0, 18'sd0},
      '{16'sd0, 16'sd1, 12'd4095, 32'hDEAD_BEEF, 1'b0, 1'b0, 18'sd0, 18'sd0},
      '{16'sd1, 16'sd1, 12'd1, 32'hCAFE_F00D, 1'b0, 1'b0, 18'sd0, 18'sd0},
      '{-16'sd1, -16'sd1, 12'd7, 32'h0000_0001, 1'b0, 1'b0, 18'sd0, 18'sd0},
      '{-16'sd5, -16'sd1, 12'd333, 32'h7FFF_FFFE, 1'b0, 1'b0, 18'sd0, 18'sd0},
      '{-16'sd5, 16'sd2000, 12'd1000, 32'hA5A5_5A5A, 1'b0, 1'b0, 18'sd0, 18'sd0}
    };
    cam_sets = '{'{16'h7FFF, 16'h8000}, '{16'h8000, 16'h7FFF},
                 '{16'h0123, 16'hFEDC}, '{16'h0000, 16'h0000}};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_point(dir_rows[i]);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      cfg_write(CfgCamX, cam_sets[ph][0]);
      cfg_write(CfgSpare, 16'($urandom));
      cfg_write(CfgCamY, cam_sets[ph][1]);
      cfg_write(CfgUnused, 16'($urandom));
      if (ph == 0) hold_off = 1'b1;
      for (int k = 0; k < 55; k++) begin
        p = random_point();
        send_point(p);
      end
      drain();
    end

    $display("covered %0d points, %0d segments, %0d vertices over 5 camera settings",
             points_sent, segments_made, vertices_seen);
    $display("including a 600-cycle output hold-off with input backpressure");
    if (errors == 0) begin
      $display("polyline_strip_extruder test passed");
    end else begin
      $display("polyline_strip_extruder test failed");
    end
    $finish;
  end

endmodule
